/* rtl/core/jls_pkg.sv */
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types, constants and saturation helpers for the jerk-limited
// setpoint smoother.
// ----------------------------------------------------------------------------
package jls_pkg;

    // Word widths: signed fixed-point data, unsigned limit registers
    localparam int DW   = 32;
    localparam int CW   = DW - 1;
    localparam int PW   = 2 * DW;
    localparam int IDXW = 3;

    // Register reset values
    localparam logic [CW-1:0] RST_MAX_VEL  = CW'(65536);
    localparam logic [CW-1:0] RST_MAX_ACC  = CW'(65536);
    localparam logic [CW-1:0] RST_MAX_JERK = CW'(65536);
    localparam logic [CW-1:0] RST_SEG_TIME = CW'(6554);
    localparam logic [CW-1:0] RST_INV_SEG  = CW'(655360);

    // Register indexes
    localparam logic [IDXW-1:0] CFG_MAX_VEL  = 3'd0;
    localparam logic [IDXW-1:0] CFG_MAX_ACC  = 3'd1;
    localparam logic [IDXW-1:0] CFG_MAX_JERK = 3'd2;
    localparam logic [IDXW-1:0] CFG_SEG_TIME = 3'd3;
    localparam logic [IDXW-1:0] CFG_INV_SEG  = 3'd4;

    typedef struct packed {
        logic signed [DW-1:0] target;
        logic                 start_req;
        logic signed [DW-1:0] initial_position;
        logic signed [DW-1:0] initial_velocity;
        logic                 last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] position_out;
        logic signed [DW-1:0] velocity_out;
        logic signed [DW-1:0] acceleration_out;
        logic                 last_out;
    } t_out_item;

    // Product steps of one update, in order
    typedef enum logic [2:0] {
        STEP_DV   = 3'd0,
        STEP_DA   = 3'd1,
        STEP_JERK = 3'd2,
        STEP_ACC  = 3'd3,
        STEP_VEL  = 3'd4,
        STEP_POS  = 3'd5
    } t_step;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_RND  = 6'b001000,
        ST_ACCU = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  prep;
        logic  mul;
        logic  rnd;
        logic  accu;
        logic  emit;
        t_step step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic run;
    } t_dp_stat;

    // Saturate a DW+1 bit signed value to DW bits
    function automatic logic signed [DW-1:0] f_sat(input logic signed [DW:0] v);
        logic signed [DW-1:0] r;
        if (v[DW] != v[DW-1]) begin
            r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // Clamp to +-lim
    function automatic logic signed [DW-1:0] f_clamp(input logic signed [DW-1:0] v,
                                                     input logic [CW-1:0] lim);
        logic signed [DW:0]   vx;
        logic signed [DW:0]   lx;
        logic signed [DW:0]   nx;
        logic signed [DW-1:0] r;
        vx = {v[DW-1], v};
        lx = $signed({2'b00, lim});
        nx = -lx;
        if (vx > lx) begin
            r = lx[DW-1:0];
        end else if (vx < nx) begin
            r = nx[DW-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/jls_ctrl.sv */
// ----------------------------------------------------------------------------
// jls_ctrl
// Sequencer: accepts a beat, walks the six product steps (when run is set)
// in the shared multiplier (prepare, multiply, round, accumulate); emits.
// ----------------------------------------------------------------------------
module jls_ctrl
    import jls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   emit;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign emit        = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Next state and step
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_stat.run ? ST_PREP : ST_EMIT;
                    n_step  = STEP_DV;
                end
            end
            ST_PREP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_RND;
            ST_RND:  n_state = ST_ACCU;
            ST_ACCU: begin
                if (r_step == STEP_POS) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PREP;
                    n_step  = t_step'(r_step + 3'd1);
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output beat pending until taken
    assign n_out_valid = emit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_DV;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands
    always_comb begin
        o_cmd.load_in = in_acc;
        o_cmd.prep    = (r_state == ST_PREP);
        o_cmd.mul     = (r_state == ST_MUL);
        o_cmd.rnd     = (r_state == ST_RND);
        o_cmd.accu    = (r_state == ST_ACCU);
        o_cmd.emit    = emit;
        o_cmd.step    = r_step;
    end

`ifndef SYNTHESIS
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_PREP || r_state == ST_EMIT))
        else $error("accepted beat did not start an update or emit");
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCU && r_step != STEP_POS) |=>
        (r_state == ST_PREP && r_step == t_step'($past(r_step) + 3'd1)))
        else $error("product step did not advance by one");
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("output beat raised outside emit");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && i_out_stall) |=> r_state == ST_EMIT)
        else $error("left emit while a stalled beat was pending");
`endif

endmodule

/* rtl/core/jls_dp.sv */
// ----------------------------------------------------------------------------
// jls_dp
// Datapath: limit registers, motion state, one shared 32x31 multiplier with
// rounding and saturation, the accumulate/clamp stage and the output register.
// ----------------------------------------------------------------------------
module jls_dp
    import jls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_data,
    input  t_in_item        i_in_data,
    input  t_dp_cmd         i_cmd,
    output t_dp_stat        o_stat,
    output t_out_item       o_out_data
);

    // Update runs only when the segment time exceeds one millisecond
    localparam longint RUN_MIN = (64'd1 << FRAC_BITS) / 1000;
    localparam logic [PW-1:0] RND_ONE = PW'(64'd1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] LIM_POS = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);

    logic [CW-1:0] r_max_vel, r_max_acc, r_max_jerk, r_seg_time, r_inv_seg;

    logic signed [DW-1:0] r_pos, r_vel, r_acc;
    logic signed [DW-1:0] r_tgt, r_tmp, r_fm;
    logic                 r_last;
    logic [DW-1:0]        r_mag;
    logic [CW-1:0]        r_mb;
    logic                 r_neg;
    logic [PW-1:0]        r_prod;
    t_out_item            r_out;

    logic signed [DW-1:0] px, py, pd;
    logic signed [DW-1:0] ab, asum, ares;
    logic [CW-1:0]        alim;
    logic [PW-1:0]        rnd, rq, rqs;

    assign o_stat.run = (r_seg_time > CW'(RUN_MIN));
    assign o_out_data = r_out;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel  <= RST_MAX_VEL;
            r_max_acc  <= RST_MAX_ACC;
            r_max_jerk <= RST_MAX_JERK;
            r_seg_time <= RST_SEG_TIME;
            r_inv_seg  <= RST_INV_SEG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_VEL:  r_max_vel  <= i_cfg_data;
                CFG_MAX_ACC:  r_max_acc  <= i_cfg_data;
                CFG_MAX_JERK: r_max_jerk <= i_cfg_data;
                CFG_SEG_TIME: r_seg_time <= i_cfg_data;
                CFG_INV_SEG:  r_inv_seg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the product of this step
    always_comb begin
        case (i_cmd.step)
            STEP_DV:   begin px = r_tgt; py = r_pos; end
            STEP_DA:   begin px = r_tmp; py = r_vel; end
            STEP_JERK: begin px = r_tmp; py = r_acc; end
            STEP_ACC:  begin px = r_tmp; py = '0;    end
            STEP_VEL:  begin px = r_acc; py = '0;    end
            STEP_POS:  begin px = r_vel; py = '0;    end
            default:   begin px = '0;    py = '0;    end
        endcase
        pd = f_sat({px[DW-1], px} - {py[DW-1], py});
    end

    // Round half away from zero, then saturate the magnitude
    always_comb begin
        rnd = r_prod + RND_ONE;
        rq  = rnd >> FRAC_BITS;
        if (r_neg) begin
            rqs = (rq > LIM_NEG) ? LIM_NEG : rq;
        end else begin
            rqs = (rq > LIM_POS) ? LIM_POS : rq;
        end
    end

    // Accumulate base and limit for this step
    always_comb begin
        case (i_cmd.step)
            STEP_DV:   begin ab = '0;    alim = r_max_vel;  end
            STEP_DA:   begin ab = '0;    alim = r_max_acc;  end
            STEP_JERK: begin ab = '0;    alim = r_max_jerk; end
            STEP_ACC:  begin ab = r_acc; alim = r_max_acc;  end
            STEP_VEL:  begin ab = r_vel; alim = r_max_vel;  end
            STEP_POS:  begin ab = r_pos; alim = '0;         end
            default:   begin ab = '0;    alim = '0;         end
        endcase
        asum = f_sat({ab[DW-1], ab} + {r_fm[DW-1], r_fm});
        ares = (i_cmd.step == STEP_POS) ? asum : f_clamp(asum, alim);
    end

    // Motion state, reset to rest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_acc <= '0;
        end else if (i_cmd.load_in && i_in_data.start_req) begin
            r_pos <= i_in_data.initial_position;
            r_vel <= i_in_data.initial_velocity;
            r_acc <= '0;
        end else if (i_cmd.accu) begin
            case (i_cmd.step)
                STEP_ACC: r_acc <= ares;
                STEP_VEL: r_vel <= ares;
                STEP_POS: r_pos <= ares;
                default: ;
            endcase
        end
    end

    // Working registers of the shared multiplier
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tgt  <= i_in_data.target;
            r_last <= i_in_data.last_in;
        end
        if (i_cmd.prep) begin
            r_mag <= pd[DW-1] ? DW'(-pd) : DW'(pd);
            r_neg <= pd[DW-1];
            r_mb  <= (i_cmd.step == STEP_DV || i_cmd.step == STEP_DA ||
                      i_cmd.step == STEP_JERK) ? r_inv_seg : r_seg_time;
        end
        if (i_cmd.mul) begin
            r_prod <= {{DW{1'b0}}, r_mag} * {{(DW+1){1'b0}}, r_mb};
        end
        if (i_cmd.rnd) begin
            r_fm <= r_neg ? -$signed(rqs[DW-1:0]) : $signed(rqs[DW-1:0]);
        end
        if (i_cmd.accu && (i_cmd.step == STEP_DV || i_cmd.step == STEP_DA ||
                           i_cmd.step == STEP_JERK)) begin
            r_tmp <= ares;
        end
        if (i_cmd.emit) begin
            r_out.position_out     <= r_pos;
            r_out.velocity_out     <= r_vel;
            r_out.acceleration_out <= r_acc;
            r_out.last_out         <= r_last;
        end
    end

endmodule

/* rtl/core/jerk_limited_setpoint_smoother.sv */
// ----------------------------------------------------------------------------
// jerk_limited_setpoint_smoother
// Tracks one target waypoint per beat with a jerk-limited profile and
// returns position, velocity and acceleration in signed Q16.16.
// ----------------------------------------------------------------------------
// One result beat per input beat. When the segment time is above one
// millisecond an accepted beat runs the update; otherwise no update runs and
// the beat goes straight to the output register. The update computes six
// dependent products, each passing through the one shared 32x31 multiplier
// in four steps (prepare operand, multiply, round and saturate,
// accumulate and clamp). A finished result waits in an output register, so
// the next beat is accepted while it is still stalled. The limit registers
// may be written at any time the block is idle; writes are always taken.
module jerk_limited_setpoint_smoother
    import jls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [IDXW-1:0] i_cfg_index,
    input  logic [CW-1:0]   i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    jls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jls_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

/* tb/jerk_limited_setpoint_smoother_tb.sv */
// ----------------------------------------------------------------------------
// jerk_limited_setpoint_smoother_tb
// Drives waypoint beats through the smoother under several limit settings and
// compares every result beat, field by field, against a local fixed-point
// tracker. The run covers a directed opening, then random trajectories with
// bursts of idling and stalling on both sides.
// ----------------------------------------------------------------------------
module jerk_limited_setpoint_smoother_tb;
    import jls_pkg::*;

    localparam int     CLK_PERIOD     = 12;
    localparam int     TIMEOUT_CYCLES = 400000;
    localparam int     FRAC_BITS      = 16;
    localparam int     RAND_PHASES    = 10;
    localparam int     PHASE_ITEMS    = 110;
    localparam longint WORD_TOP       = 64'sd2147483647;
    localparam longint WORD_MIN       = -WORD_TOP - 1;
    localparam longint Q_ONE          = 64'sd65536;
    // Index with no register behind it
    localparam logic [IDXW-1:0] CFG_NONE = 3'd7;

    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [IDXW-1:0] i_cfg_index = '0;
    logic [CW-1:0]   i_cfg_data  = '0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_data;

    // Tracker copy of the limits and the motion state
    longint lim_vel, lim_acc, lim_jerk, seg_time, inv_seg;
    longint trk_pos, trk_vel, trk_acc;

    t_in_item  waypoint_q[$];
    t_out_item awaited_states[$];
    int        queued_n   = 0;
    int        accepted_n = 0;
    int        fail_count = 0;
    int        idle_pct   = 0;
    int        in_gap     = 0;
    int        stall_left = 0;

    jerk_limited_setpoint_smoother dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic longint sat_word(input longint v);
        if (v > WORD_TOP) return WORD_TOP;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint clamp_lim(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Fixed-point product: round half away from zero, saturate to the word
    function automatic longint fx_mul(input longint x, input longint y);
        bit     neg;
        longint mx, my, q, top;
        neg = (x < 0) != (y < 0);
        mx  = (x < 0) ? -x : x;
        my  = (y < 0) ? -y : y;
        q   = (mx * my + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        top = neg ? WORD_TOP + 1 : WORD_TOP;
        if (q > top) q = top;
        return neg ? -q : q;
    endfunction

    // Advance the tracker by one waypoint and return the state it settles on
    function automatic t_out_item smooth_waypoint(input t_in_item it);
        longint    p, v, a, dv, da, jk;
        t_out_item r;
        p = trk_pos;
        v = trk_vel;
        a = trk_acc;
        if (it.start_req) begin
            p = longint'(it.initial_position);
            v = longint'(it.initial_velocity);
            a = 0;
        end
        // Segments of a millisecond or less hold the state
        if (seg_time * 1000 > (64'sd1 <<< FRAC_BITS)) begin
            dv = clamp_lim(fx_mul(sat_word(longint'(it.target) - p), inv_seg), lim_vel);
            da = clamp_lim(fx_mul(sat_word(dv - v), inv_seg), lim_acc);
            jk = clamp_lim(fx_mul(sat_word(da - a), inv_seg), lim_jerk);
            a  = clamp_lim(sat_word(a + fx_mul(jk, seg_time)), lim_acc);
            v  = clamp_lim(sat_word(v + fx_mul(a, seg_time)), lim_vel);
            p  = sat_word(p + fx_mul(v, seg_time));
        end
        trk_pos = p;
        trk_vel = v;
        trk_acc = a;
        r.position_out     = p[DW-1:0];
        r.velocity_out     = v[DW-1:0];
        r.acceleration_out = a[DW-1:0];
        r.last_out         = it.last_in;
        return r;
    endfunction

    function automatic longint spread(input int unsigned r);
        return longint'($urandom_range(2 * r, 0)) - longint'(r);
    endfunction

    function automatic longint pick_limit();
        longint v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = WORD_TOP;
            2:       v = longint'($urandom) & WORD_TOP;
            default: v = longint'($urandom_range(40 * 65536, 16384));
        endcase
        return v;
    endfunction

    task automatic report_miss(input string what, input longint want, input longint got);
        if (fail_count < 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
        fail_count++;
    endtask

    task automatic push_waypoint(input longint tgt, input bit st, input longint ip,
                                 input longint iv, input bit last);
        t_in_item it;
        it.target           = tgt[DW-1:0];
        it.start_req        = st;
        it.initial_position = ip[DW-1:0];
        it.initial_velocity = iv[DW-1:0];
        it.last_in          = last;
        waypoint_q.push_back(it);
        queued_n++;
    endtask

    // Write one register; valid stays up until the phase begins
    task automatic set_reg(input logic [IDXW-1:0] idx, input longint val);
        logic [CW-1:0] word;
        word = val[CW-1:0];
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_VEL:  lim_vel  = longint'(word);
            CFG_MAX_ACC:  lim_acc  = longint'(word);
            CFG_MAX_JERK: lim_jerk = longint'(word);
            CFG_SEG_TIME: seg_time = longint'(word);
            CFG_INV_SEG:  inv_seg  = longint'(word);
            default: ;
        endcase
    endtask

    task automatic begin_phase(input int pct);
        i_cfg_valid <= 1'b0;
        idle_pct = pct;
    endtask

    // Wait until every queued beat has gone in and its result has come back
    task automatic settle();
        while (accepted_n != queued_n || awaited_states.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Input driver: predict on acceptance, hold a stalled beat, idle in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_states.push_back(smooth_waypoint(i_in_data));
                accepted_n++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap--;
                end else if (waypoint_q.size() != 0 && idle_pct != 0 &&
                             $urandom_range(99) < idle_pct) begin
                    i_in_valid <= 1'b0;
                    in_gap = int'($urandom_range(6, 1)) - 1;
                end else if (waypoint_q.size() != 0) begin
                    i_in_data  <= waypoint_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest prediction, stall in bursts
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_states.size() == 0) begin
                    report_miss("unexpected result beat", 0,
                                longint'(o_out_data.position_out));
                end else begin
                    want = awaited_states.pop_front();
                    if (o_out_data.position_out !== want.position_out)
                        report_miss("position_out", longint'(want.position_out),
                                    longint'(o_out_data.position_out));
                    if (o_out_data.velocity_out !== want.velocity_out)
                        report_miss("velocity_out", longint'(want.velocity_out),
                                    longint'(o_out_data.velocity_out));
                    if (o_out_data.acceleration_out !== want.acceleration_out)
                        report_miss("acceleration_out", longint'(want.acceleration_out),
                                    longint'(o_out_data.acceleration_out));
                    if (o_out_data.last_out !== want.last_out)
                        report_miss("last_out", longint'(want.last_out),
                                    longint'(o_out_data.last_out));
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                i_out_stall <= 1'b1;
                stall_left = int'($urandom_range(6, 1)) - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int     made, len, pct;
        longint walk, seg, inv;

        lim_vel  = longint'(RST_MAX_VEL);
        lim_acc  = longint'(RST_MAX_ACC);
        lim_jerk = longint'(RST_MAX_JERK);
        seg_time = longint'(RST_SEG_TIME);
        inv_seg  = longint'(RST_INV_SEG);
        trk_pos  = 0;
        trk_vel  = 0;
        trk_acc  = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: field extremes, saturating errors, oversized start velocity
        begin_phase(30);
        push_waypoint(5 * Q_ONE, 1'b1, 0, 0, 1'b0);
        push_waypoint(WORD_TOP, 1'b0, longint'($urandom), longint'($urandom), 1'b0);
        push_waypoint(WORD_MIN, 1'b0, longint'($urandom), longint'($urandom), 1'b0);
        push_waypoint(0, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        push_waypoint(WORD_MIN, 1'b1, WORD_TOP, WORD_TOP, 1'b0);
        push_waypoint(WORD_TOP, 1'b1, WORD_MIN, WORD_MIN, 1'b1);
        push_waypoint(-1, 1'b1, Q_ONE, 10 * Q_ONE, 1'b0);
        push_waypoint(1, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        settle();

        // Zero limits clamp everything to zero
        set_reg(CFG_MAX_VEL, 0);
        set_reg(CFG_MAX_ACC, 0);
        set_reg(CFG_MAX_JERK, 0);
        begin_phase(30);
        push_waypoint(3 * Q_ONE, 1'b1, 0, 2 * Q_ONE, 1'b0);
        push_waypoint(-Q_ONE, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        settle();

        // Every register at its top value
        set_reg(CFG_MAX_VEL, WORD_TOP);
        set_reg(CFG_MAX_ACC, WORD_TOP);
        set_reg(CFG_MAX_JERK, WORD_TOP);
        set_reg(CFG_SEG_TIME, WORD_TOP);
        set_reg(CFG_INV_SEG, WORD_TOP);
        begin_phase(0);
        push_waypoint(WORD_TOP, 1'b1, WORD_MIN, 0, 1'b0);
        push_waypoint(WORD_MIN, 1'b0, longint'($urandom), longint'($urandom), 1'b0);
        push_waypoint(0, 1'b1, WORD_TOP, WORD_MIN, 1'b1);
        settle();

        // Short segment: just at a millisecond the state holds, one step above it moves
        set_reg(CFG_MAX_VEL, 4 * Q_ONE);
        set_reg(CFG_MAX_ACC, 4 * Q_ONE);
        set_reg(CFG_MAX_JERK, 4 * Q_ONE);
        set_reg(CFG_SEG_TIME, 65);
        set_reg(CFG_INV_SEG, 1000 * Q_ONE);
        begin_phase(30);
        push_waypoint(Q_ONE, 1'b1, 2 * Q_ONE, Q_ONE, 1'b0);
        push_waypoint(-Q_ONE, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        settle();
        set_reg(CFG_SEG_TIME, 66);
        begin_phase(30);
        push_waypoint(Q_ONE, 1'b0, longint'($urandom), longint'($urandom), 1'b0);
        push_waypoint(Q_ONE, 1'b1, 0, 0, 1'b1);
        settle();
        set_reg(CFG_SEG_TIME, 0);
        begin_phase(30);
        push_waypoint(Q_ONE, 1'b1, 5 * Q_ONE, -Q_ONE, 1'b1);
        settle();

        // Inverse that does not match the segment time; write to an unused index
        set_reg(CFG_SEG_TIME, 6554);
        set_reg(CFG_INV_SEG, 0);
        set_reg(CFG_NONE, WORD_TOP);
        begin_phase(30);
        push_waypoint(4 * Q_ONE, 1'b1, 0, Q_ONE, 1'b0);
        push_waypoint(4 * Q_ONE, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        settle();
        set_reg(CFG_INV_SEG, 3 * Q_ONE);
        begin_phase(30);
        push_waypoint(-4 * Q_ONE, 1'b1, Q_ONE, 0, 1'b0);
        push_waypoint(-4 * Q_ONE, 1'b0, longint'($urandom), longint'($urandom), 1'b1);
        settle();

        // Random settings, mostly well-formed trajectories with some noise beats
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(9))
                0:       seg = longint'($urandom_range(65, 0));
                1:       seg = longint'($urandom_range(655, 66));
                2:       seg = longint'($urandom) & WORD_TOP;
                default: seg = longint'($urandom_range(32768, 655));
            endcase
            if (seg == 0 || $urandom_range(9) == 0) begin
                inv = longint'($urandom) & WORD_TOP;
            end else begin
                inv = ((64'sd1 <<< 32) + seg / 2) / seg;
                if (inv > WORD_TOP) inv = WORD_TOP;
            end
            set_reg(CFG_MAX_VEL, pick_limit());
            set_reg(CFG_MAX_ACC, pick_limit());
            set_reg(CFG_MAX_JERK, pick_limit());
            set_reg(CFG_SEG_TIME, seg);
            set_reg(CFG_INV_SEG, inv);
            case (ph % 3)
                0:       pct = 0;
                1:       pct = 20;
                default: pct = 45;
            endcase
            // No idling in the closing phase
            begin_phase((ph == RAND_PHASES - 1) ? 0 : pct);
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    push_waypoint(longint'($signed($urandom)), 1'($urandom_range(1)),
                                  longint'($signed($urandom)),
                                  longint'($signed($urandom)), 1'($urandom_range(1)));
                    made++;
                end else begin
                    len  = int'($urandom_range(24, 3));
                    walk = spread(100 * 65536);
                    push_waypoint(walk + spread(4 * 65536), 1'b1, walk,
                                  spread(3 * 65536), 1'b0);
                    for (int k = 1; k < len; k++) begin
                        walk += spread(2 * 65536);
                        push_waypoint(walk, 1'b0, longint'($signed($urandom)),
                                      longint'($signed($urandom)), k == len - 1);
                    end
                    made += len;
                end
            end
            settle();
        end

        // Let any stray beat show up before the verdict
        repeat (30) @(posedge i_clk);
        if (awaited_states.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("jerk_limited_setpoint_smoother_tb passed");
        end else begin
            $display("jerk_limited_setpoint_smoother_tb failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("jerk_limited_setpoint_smoother_tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/jls_pkg.sv
rtl/core/jls_ctrl.sv
rtl/core/jls_dp.sv
rtl/core/jerk_limited_setpoint_smoother.sv
tb/jerk_limited_setpoint_smoother_tb.sv
